// ----- hdl/cubic_bezier_point_eval_assert.svh -----
// Assertion macros used by the checker module of this block.
// Each macro takes a label, the clock, the active-low reset, and the two
// sides of the implication.
`ifndef CUBIC_BEZIER_POINT_EVAL_ASSERT_SVH
`define CUBIC_BEZIER_POINT_EVAL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBEZ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cubic_bezier_point_eval assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CBEZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cubic_bezier_point_eval assertion failed");

`endif

// ----- hdl/cbez_pkg.sv -----
package cbez_pkg;

	// Number of control points the curve is built from, and the register file size.
	localparam int NUM_POINTS = 4;
	localparam int REG_COUNT  = 4;

	// Points actually in use: clamped to the register file and to at least two.
	localparam int PT_COUNT = (NUM_POINTS > REG_COUNT) ? REG_COUNT :
	                          ((NUM_POINTS < 2) ? 2 : NUM_POINTS);

	// One interpolation round per pipeline stage, plus the stage that takes t.
	localparam int ROUNDS     = PT_COUNT - 1;
	localparam int NUM_STAGES = ROUNDS + 1;

	localparam int COORD_W = 16;
	localparam int FRAC_W  = 16;
	localparam int T_W     = FRAC_W + 1;
	localparam int REG_W   = 3 * COORD_W;
	localparam int IDX_W   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int PROD_W  = (COORD_W + 1) + (T_W + 1);

	localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_W;

	typedef logic signed [COORD_W-1:0] coord_t;

	// Same packing as a control point register: x high, z low.
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	// Reset control points: (-20,-20,7), (-20,20,7), (20,-20,7), (20,20,7) in Q8.8.
	localparam logic [REG_W-1:0] CP_RESET [REG_COUNT] = '{
		48'hEC00_EC00_0700,
		48'hEC00_1400_0700,
		48'h1400_EC00_0700,
		48'h1400_1400_0700
	};

	// floor((a*(1-t) + b*t)) written as a + floor((b-a)*t / 2^16).
	// The result is a convex combination, so the low bits are exact.
	function automatic coord_t lerp_coord(coord_t a, coord_t b, logic [T_W-1:0] t);
		logic signed [COORD_W:0]  diff;
		logic signed [PROD_W-1:0] prod;
		diff = {b[COORD_W-1], b} - {a[COORD_W-1], a};
		prod = diff * $signed({1'b0, t});
		return coord_t'(a + prod[FRAC_W+COORD_W-1:FRAC_W]);
	endfunction

	function automatic point_t lerp_point(point_t a, point_t b, logic [T_W-1:0] t);
		point_t p;
		p.x = lerp_coord(a.x, b.x, t);
		p.y = lerp_coord(a.y, b.y, t);
		p.z = lerp_coord(a.z, b.z, t);
		return p;
	endfunction

endpackage

// ----- hdl/cubic_bezier_point_eval.sv -----
// Cubic Bezier point evaluator, de Casteljau scheme, signed Q8.8 coordinates.
// Control points are written through a plain write port (cfg_wr_en, cfg_index,
// cfg_wdata); each register packs x in bits 47:32, y in 31:16 and z in 15:0.
// The user must write registers only while no beat is in flight; the block does not enforce this.
// Request channel: param_valid / param_stall carry curve_param, the curve
// parameter t in unsigned Q1.16; values above 1.0 are saturated to 1.0.
// Result channel: point_valid / point_stall carry point_x, point_y, point_z.
// A beat moves at a rising edge where valid is high and stall is low.
// Path: a beat is registered in the t stage and then in each of the ROUNDS
// interpolation round stages before it is presented on point_valid; each round
// owns one register stage with its own multipliers, so a new beat is accepted
// every cycle while the receiver does not stall.
// When the receiver stalls, the pipeline compresses bubbles first and only then
// raises param_stall; no beat is lost or repeated.
// Reset clears every valid bit and loads the default control points.
module cubic_bezier_point_eval (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          param_valid,
	output logic                          param_stall,
	input  logic [cbez_pkg::T_W-1:0]      curve_param,
	output logic                          point_valid,
	input  logic                          point_stall,
	output cbez_pkg::coord_t              point_x,
	output cbez_pkg::coord_t              point_y,
	output cbez_pkg::coord_t              point_z,
	input  logic                          cfg_wr_en,
	input  logic [cbez_pkg::IDX_W-1:0]    cfg_index,
	input  logic [cbez_pkg::REG_W-1:0]    cfg_wdata
);
	import cbez_pkg::*;

	// Control point registers.
	logic [REG_W-1:0] ctrl_q [REG_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				ctrl_q[i] <= CP_RESET[i];
			end
		end else if (cfg_wr_en && ({1'b0, cfg_index} < (IDX_W+1)'(REG_COUNT))) begin
			ctrl_q[cfg_index] <= cfg_wdata;
		end
	end

	// Pipeline state. Stage 0 holds the clamped t; stage r holds the points
	// left after interpolation round r.
	logic             vld_s [0:ROUNDS];
	logic             rdy   [0:ROUNDS];
	logic [T_W-1:0]   t_s   [0:ROUNDS-1];
	point_t           pt_s  [1:ROUNDS][PT_COUNT];

	// A stage can load when it is empty or when its contents move on this
	// cycle. The last stage is the output register.
	always_comb begin
		rdy[ROUNDS] = !vld_s[ROUNDS] || !point_stall;
		for (int k = ROUNDS - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	assign param_stall = !rdy[0];

	// Stage 0: capture t, saturated to 1.0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_s[0] <= param_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && param_valid) begin
			t_s[0] <= (curve_param > T_ONE) ? T_ONE : curve_param;
		end
	end

	// Interpolation rounds. Round r turns PT_COUNT-r+1 points into PT_COUNT-r.
	for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
		point_t src [PT_COUNT-r+1];

		if (r == 1) begin : g_first
			for (genvar i = 0; i < PT_COUNT; i++) begin : g_src
				assign src[i] = point_t'(ctrl_q[i]);
			end
		end else begin : g_next
			for (genvar i = 0; i < PT_COUNT - r + 1; i++) begin : g_src
				assign src[i] = pt_s[r-1][i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[r] <= 1'b0;
			end else if (rdy[r]) begin
				vld_s[r] <= vld_s[r-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[r] && vld_s[r-1]) begin
				for (int i = 0; i < PT_COUNT - r; i++) begin
					pt_s[r][i] <= lerp_point(src[i], src[i+1], t_s[r-1]);
				end
			end
		end

		// t travels along with the points for the rounds still ahead.
		if (r < ROUNDS) begin : g_t
			always_ff @(posedge clk) begin
				if (rdy[r] && vld_s[r-1]) begin
					t_s[r] <= t_s[r-1];
				end
			end
		end
	end

	assign point_valid = vld_s[ROUNDS];
	assign point_x     = pt_s[ROUNDS][0].x;
	assign point_y     = pt_s[ROUNDS][0].y;
	assign point_z     = pt_s[ROUNDS][0].z;

endmodule

// ----- hdl/cbez_checker.sv -----
`include "cubic_bezier_point_eval_assert.svh"

module cbez_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       param_valid,
	input logic                       param_stall,
	input logic                       point_valid,
	input logic                       point_stall,
	input cbez_pkg::coord_t           point_x,
	input cbez_pkg::coord_t           point_y,
	input cbez_pkg::coord_t           point_z
);
	import cbez_pkg::*;

	localparam int CNT_W = $clog2(NUM_STAGES + 1) + 1;

	logic             acc_in;
	logic             acc_out;
	logic [CNT_W-1:0] inflight_q;

	assign acc_in  = param_valid && !param_stall;
	assign acc_out = point_valid && !point_stall;

	// Beats accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(acc_in) - CNT_W'(acc_out);
		end
	end

	// A stalled result holds its value.
	`CBEZ_ASSERT_NEXT(a_hold, clk, arst_n, point_valid && point_stall, point_valid && $stable(point_x) && $stable(point_y) && $stable(point_z))
	// Without back-pressure from the receiver the pipeline always takes a beat.
	`CBEZ_ASSERT_SAME(a_no_stall, clk, arst_n, !point_stall, !param_stall)
	// A result is only offered for a beat that was accepted earlier.
	`CBEZ_ASSERT_SAME(a_no_invent, clk, arst_n, point_valid, inflight_q != '0)
	// The pipeline never holds more beats than it has stages.
	`CBEZ_ASSERT_SAME(a_capacity, clk, arst_n, 1'b1, inflight_q <= CNT_W'(NUM_STAGES))

endmodule

bind cubic_bezier_point_eval cbez_checker u_cbez_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.param_valid (param_valid),
	.param_stall (param_stall),
	.point_valid (point_valid),
	.point_stall (point_stall),
	.point_x     (point_x),
	.point_y     (point_y),
	.point_z     (point_z)
);
